[rtl/core/hcmh_pkg.sv]
// hcmh_pkg: shared constants and state encodings for the huffman cost min-heap core
// no dependencies
package hcmh_pkg;

  // default sizing of the weight store
  localparam int MAX_SYMBOLS_DEF = 64;
  localparam int FREQ_BITS_DEF   = 16;

  // fixed widths of the item and result fields
  localparam int FREQ_W  = 16;
  localparam int COST_W  = 32;
  localparam int COUNT_W = 7;

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_HEAP_NEXT = 12'b0000_0000_0010,
    ST_GET_V     = 12'b0000_0000_0100,
    ST_SD_RD     = 12'b0000_0000_1000,
    ST_SD_CMP1   = 12'b0000_0001_0000,
    ST_SD_CMP2   = 12'b0000_0010_0000,
    ST_MERGE     = 12'b0000_0100_0000,
    ST_POP       = 12'b0000_1000_0000,
    ST_REPL_RD   = 12'b0001_0000_0000,
    ST_REPL      = 12'b0010_0000_0000,
    ST_COST      = 12'b0100_0000_0000,
    ST_OUT       = 12'b1000_0000_0000
  } state_t;

  // what a finished sift-down returns to
  typedef enum logic [2:0] {
    PH_BUILD = 3'b001,
    PH_POP   = 3'b010,
    PH_REPL  = 3'b100
  } phase_t;

endpackage

[rtl/core/hcmh_ram.sv]
// hcmh_ram: generic single-write, dual-read RAM with registered read data
// no dependencies
module hcmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[rtl/core/hcmh_min_unit.sv]
// hcmh_min_unit: shared weight comparator, picks the smaller of two weights
// no dependencies
module hcmh_min_unit #(
  parameter int WIDTH = 8
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             b_ok,
  output logic             take_b,
  output logic [WIDTH-1:0] min_val
);

  // b wins only when present and strictly smaller, so ties keep a
  assign take_b  = b_ok && (b < a);
  assign min_val = take_b ? b : a;

endmodule

[rtl/core/huffman_cost_min_heap_core.sv]
// huffman_cost_min_heap_core: optimal huffman weighted path length over a min-heap
// depends on hcmh_pkg, hcmh_ram and hcmh_min_unit
//
// Frequencies arrive one item per cycle while the core is idle; zero ones are skipped and
// nonzero ones are appended to a MAX_SYMBOLS-entry weight RAM (extra ones set the overflow
// flag and are dropped). The item with last set also starts the computation and in_ready stays
// low until it ends: the RAM is heapified bottom-up, then the two smallest weights are merged
// repeatedly (pop the root, add it to the new root, sift the sum down) until one weight is
// left. Every step runs through one sift-down sequencer with a single shared comparator and a
// RAM with registered reads, so each heap level takes a read, a compare of the two children and
// a compare of the smaller child against the moving weight. One result item carries the
// saturating 32-bit cost (0 for zero or one symbol), the accepted symbol count and the overflow
// flag; the core then clears itself and may take the next set's items while that result still
// waits on out_ready.
module huffman_cost_min_heap_core #(
  parameter int MAX_SYMBOLS = hcmh_pkg::MAX_SYMBOLS_DEF,
  parameter int FREQ_BITS   = hcmh_pkg::FREQ_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hcmh_pkg::FREQ_W-1:0]  in_frequency,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hcmh_pkg::COST_W-1:0]  out_total_cost,
  output logic [hcmh_pkg::COUNT_W-1:0] out_symbol_count,
  output logic                         out_overflow
);

  localparam int AW      = $clog2(MAX_SYMBOLS);
  localparam int W       = FREQ_BITS + AW;
  localparam int CW      = $clog2(MAX_SYMBOLS + 1);
  localparam int IW      = CW + 1;
  localparam int FB_USED = (FREQ_BITS < hcmh_pkg::FREQ_W) ? FREQ_BITS : hcmh_pkg::FREQ_W;
  localparam logic [hcmh_pkg::FREQ_W-1:0] FMASK =
    hcmh_pkg::FREQ_W'((64'(1) << FB_USED) - 64'(1));

  hcmh_pkg::state_t state_r, state_nxt;
  hcmh_pkg::phase_t phase_r, phase_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] heap_n_r, heap_n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] cpos_r, cpos_nxt;
  logic [W-1:0]  v_r, v_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  cv_r, cv_nxt;
  logic [hcmh_pkg::COST_W-1:0] cost_r, cost_nxt;
  logic          ovf_r, ovf_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [hcmh_pkg::COST_W-1:0]  out_cost_r, out_cost_nxt;
  logic [hcmh_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                         out_ovf_r, out_ovf_nxt;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [AW-1:0] ram_raddr0;
  logic [AW-1:0] ram_raddr1;
  logic [W-1:0]  ram_rdata0;
  logic [W-1:0]  ram_rdata1;

  // shared comparator ports
  logic [W-1:0] cmp_a;
  logic [W-1:0] cmp_b;
  logic         cmp_b_ok;
  logic         cmp_take_b;
  logic [W-1:0] cmp_min;

  logic [hcmh_pkg::FREQ_W-1:0] f_masked;
  logic [W-1:0]                f_w;
  logic                        f_nz;
  logic                        full;
  logic                        in_acc;
  logic [CW-1:0]               cnt_inc;
  logic [IW-1:0]               c_idx;
  logic [IW-1:0]               c1_idx;
  logic                        has_child;
  logic                        has_right;
  logic                        sift_done;
  logic                        out_load;
  logic [hcmh_pkg::COST_W:0]   cost_sum_ext;

  hcmh_ram #(
    .WIDTH (W),
    .DEPTH (MAX_SYMBOLS)
  ) u_heap_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  hcmh_min_unit #(
    .WIDTH (W)
  ) u_min (
    .a       (cmp_a),
    .b       (cmp_b),
    .b_ok    (cmp_b_ok),
    .take_b  (cmp_take_b),
    .min_val (cmp_min)
  );

  // input item decode
  assign f_masked = in_frequency & FMASK;
  assign f_w      = W'(f_masked);
  assign f_nz     = |f_masked;
  assign full     = (cnt_r == CW'(MAX_SYMBOLS));
  assign cnt_inc  = (f_nz && !full) ? cnt_r + CW'(1) : cnt_r;
  assign in_ready = (state_r == hcmh_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // heap child indexes, 1-based
  assign c_idx     = pos_r << 1;
  assign c1_idx    = c_idx + IW'(1);
  assign has_child = (c_idx <= IW'(heap_n_r));
  assign has_right = (c1_idx <= IW'(heap_n_r));

  // comparator operand select: children first, then winner against moving weight
  always_comb begin
    if (state_r == hcmh_pkg::ST_SD_CMP1) begin
      cmp_a    = ram_rdata0;
      cmp_b    = ram_rdata1;
      cmp_b_ok = has_right;
    end else begin
      cmp_a    = v_r;
      cmp_b    = cv_r;
      cmp_b_ok = 1'b1;
    end
  end

  // saturating cost accumulate
  assign cost_sum_ext = {1'b0, cost_r} + (hcmh_pkg::COST_W + 1)'(v_r);

  assign out_load = (state_r == hcmh_pkg::ST_OUT) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    heap_n_nxt = heap_n_r;
    i_nxt      = i_r;
    pos_nxt    = pos_r;
    cpos_nxt   = cpos_r;
    v_nxt      = v_r;
    a_nxt      = a_r;
    cv_nxt     = cv_r;
    cost_nxt   = cost_r;
    ovf_nxt    = ovf_r;
    ram_we     = 1'b0;
    ram_waddr  = AW'(pos_r - IW'(1));
    ram_wdata  = v_r;
    ram_raddr0 = '0;
    ram_raddr1 = '0;
    sift_done  = 1'b0;

    unique case (state_r)
      hcmh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (f_nz) begin
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(cnt_r);
              ram_wdata = f_w;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          cnt_nxt = cnt_inc;
          if (in_last) begin
            heap_n_nxt = cnt_inc;
            i_nxt      = cnt_inc >> 1;
            phase_nxt  = hcmh_pkg::PH_BUILD;
            state_nxt  = hcmh_pkg::ST_HEAP_NEXT;
          end
        end
      end
      hcmh_pkg::ST_HEAP_NEXT: begin
        if (i_r == '0) begin
          state_nxt = hcmh_pkg::ST_MERGE;
        end else begin
          ram_raddr0 = AW'(i_r - CW'(1));
          pos_nxt    = IW'(i_r);
          state_nxt  = hcmh_pkg::ST_GET_V;
        end
      end
      hcmh_pkg::ST_GET_V: begin
        v_nxt     = ram_rdata0;
        state_nxt = hcmh_pkg::ST_SD_RD;
      end
      hcmh_pkg::ST_SD_RD: begin
        if (!has_child) begin
          ram_we    = 1'b1;
          sift_done = 1'b1;
        end else begin
          ram_raddr0 = AW'(c_idx - IW'(1));
          ram_raddr1 = AW'(c_idx);
          state_nxt  = hcmh_pkg::ST_SD_CMP1;
        end
      end
      hcmh_pkg::ST_SD_CMP1: begin
        cv_nxt    = cmp_min;
        cpos_nxt  = cmp_take_b ? c1_idx : c_idx;
        state_nxt = hcmh_pkg::ST_SD_CMP2;
      end
      hcmh_pkg::ST_SD_CMP2: begin
        ram_we = 1'b1;
        if (cmp_take_b) begin
          // child is smaller: move it up and descend
          ram_wdata = cv_r;
          pos_nxt   = cpos_r;
          state_nxt = hcmh_pkg::ST_SD_RD;
        end else begin
          sift_done = 1'b1;
        end
      end
      hcmh_pkg::ST_MERGE: begin
        if (heap_n_r <= CW'(1)) begin
          state_nxt = hcmh_pkg::ST_OUT;
        end else begin
          ram_raddr0 = '0;
          ram_raddr1 = AW'(heap_n_r - CW'(1));
          state_nxt  = hcmh_pkg::ST_POP;
        end
      end
      hcmh_pkg::ST_POP: begin
        a_nxt      = ram_rdata0;
        v_nxt      = ram_rdata1;
        heap_n_nxt = heap_n_r - CW'(1);
        pos_nxt    = IW'(1);
        phase_nxt  = hcmh_pkg::PH_POP;
        state_nxt  = hcmh_pkg::ST_SD_RD;
      end
      hcmh_pkg::ST_REPL_RD: begin
        ram_raddr0 = '0;
        state_nxt  = hcmh_pkg::ST_REPL;
      end
      hcmh_pkg::ST_REPL: begin
        v_nxt     = a_r + ram_rdata0;
        state_nxt = hcmh_pkg::ST_COST;
      end
      hcmh_pkg::ST_COST: begin
        cost_nxt  = cost_sum_ext[hcmh_pkg::COST_W] ? '1 : cost_sum_ext[hcmh_pkg::COST_W-1:0];
        pos_nxt   = IW'(1);
        phase_nxt = hcmh_pkg::PH_REPL;
        state_nxt = hcmh_pkg::ST_SD_RD;
      end
      hcmh_pkg::ST_OUT: begin
        if (out_load) begin
          cnt_nxt    = '0;
          heap_n_nxt = '0;
          cost_nxt   = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = hcmh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hcmh_pkg::ST_IDLE;
      end
    endcase

    // sift-down finished: return to the caller
    if (sift_done) begin
      unique case (phase_r)
        hcmh_pkg::PH_BUILD: begin
          i_nxt     = i_r - CW'(1);
          state_nxt = hcmh_pkg::ST_HEAP_NEXT;
        end
        hcmh_pkg::PH_POP: begin
          state_nxt = hcmh_pkg::ST_REPL_RD;
        end
        hcmh_pkg::PH_REPL: begin
          state_nxt = hcmh_pkg::ST_MERGE;
        end
        default: begin
          state_nxt = hcmh_pkg::ST_MERGE;
        end
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_cost_nxt  = out_cost_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_cost_nxt  = cost_r;
      out_cnt_nxt   = hcmh_pkg::COUNT_W'(cnt_r);
      out_ovf_nxt   = ovf_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcmh_pkg::ST_IDLE;
      phase_r     <= hcmh_pkg::PH_BUILD;
      cnt_r       <= '0;
      heap_n_r    <= '0;
      cost_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      heap_n_r    <= heap_n_nxt;
      cost_r      <= cost_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    pos_r      <= pos_nxt;
    cpos_r     <= cpos_nxt;
    v_r        <= v_nxt;
    a_r        <= a_nxt;
    cv_r       <= cv_nxt;
    out_cost_r <= out_cost_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_total_cost   = out_cost_r;
  assign out_symbol_count = out_cnt_r;
  assign out_overflow     = out_ovf_r;

  // working heap size never exceeds the accepted count, which never exceeds the store
  a_heap_size: assert property (@(posedge clk) disable iff (!rst_n)
    (heap_n_r <= cnt_r) && (cnt_r <= CW'(MAX_SYMBOLS)))
    else $error("heap size out of range");

  // compare steps only ever work on a node inside the heap
  a_sift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcmh_pkg::ST_SD_CMP1 || state_r == hcmh_pkg::ST_SD_CMP2) |->
      (pos_r != '0) && (pos_r <= IW'(heap_n_r)))
    else $error("sift position outside heap");

  // handing off a result clears the set and raises out_valid
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hcmh_pkg::ST_OUT && (!out_valid_r || out_ready)) |=>
      (cnt_r == '0) && (cost_r == '0) && !ovf_r && out_valid_r &&
      (state_r == hcmh_pkg::ST_IDLE))
    else $error("set not cleared after result");

endmodule
